/* sv/mdp_pkg.sv */
// Package for the modular dot product block: widths, shared types and defaults.
// It has no dependencies. The interfaces and every module import it.
`timescale 1ns / 1ps

package mdp_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned ProdW = 2 * WordW;
  localparam int unsigned AccW  = 3 * WordW;
  localparam int unsigned RedCntW = $clog2(AccW);

  localparam int unsigned QueueDepthDef = 2;
  localparam logic [WordW-1:0] ModulusReset = WordW'(1);

  typedef logic [AccW-1:0] acc_t;

  // One finished 192-bit total travelling from the front to the back.
  typedef struct packed {
    logic valid;
    acc_t total;
  } total_req_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } back_state_e;

endpackage

/* sv/mdp_if.sv */
// Channel interfaces of the modular dot product block: input pairs, residues
// and modulus writes. Depends on mdp_pkg.
`timescale 1ns / 1ps

interface mdp_in_if import mdp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] x_value;
  logic [WordW-1:0] y_value;
  logic             last;

  modport source (output valid, x_value, y_value, last, input ready);
  modport sink   (input valid, x_value, y_value, last, output ready);
endinterface

interface mdp_out_if import mdp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] residue;

  modport source (output valid, residue, input ready);
  modport sink   (input valid, residue, output ready);
endinterface

interface mdp_cfg_if import mdp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/modular_dot_product_64.sv */
// Top level of the modular dot product block: modulus register and the
// front, queue and back parts. Depends on mdp_pkg, mdp_if and the three parts.
`timescale 1ns / 1ps

// The block takes one pair of 64-bit entries per cycle and adds their exact
// 128-bit product into a 192-bit accumulator; a pair passes the operand,
// partial product and product registers on its way to the accumulator. When
// the pair marked last has been added, the total goes into a queue of
// QueueDepth entries and the accumulator starts again from zero. The reduction
// unit works on one total at a time, one bit a cycle, and takes the next total
// from the queue only once the residue of the last has been loaded into the
// output register; the input only stalls when finished totals arrive faster
// than the reduction unit drains the queue. Write the modulus only while the
// block is idle. A zero modulus gives a residue of zero.

module modular_dot_product_64 import mdp_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mdp_in_if.sink    in_i,
  mdp_out_if.source out_o,
  mdp_cfg_if.sink   cfg_i
);

  logic [WordW-1:0] modulus_q;
  total_req_t       push;
  total_req_t       head;
  logic             full;
  logic             pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_i.valid) begin
      modulus_q <= cfg_i.data;
    end
  end

  mdp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .full_i (full)
  );

  mdp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  mdp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .modulus_i (modulus_q),
    .out_o     (out_o)
  );

endmodule

/* sv/mdp_front.sv */
// Front part: takes one pair per cycle while ready, forms the 128-bit product
// in partial products, adds it to the 192-bit accumulator. Uses mdp_pkg, mdp_if.
`timescale 1ns / 1ps

module mdp_front import mdp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mdp_in_if.sink     in_i,
  output total_req_t push_o,
  input  logic       full_i
);

  logic             advance;
  logic             v1_q, v2_q, v3_q;
  logic             last1_q, last2_q, last3_q;
  logic [WordW-1:0] x1_q, y1_q;
  logic [WordW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [WordW-1:0] p00_d, p01_d, p10_d, p11_d;
  logic [ProdW-1:0] prod_q;
  logic [ProdW-1:0] prod_sum;
  acc_t             acc_q, sum;

  // The whole pipeline holds only when a finished total finds the queue full.
  assign advance    = !(v3_q && last3_q && full_i);
  assign in_i.ready = advance;

  assign p00_d = x1_q[HalfW-1:0]     * y1_q[HalfW-1:0];
  assign p01_d = x1_q[HalfW-1:0]     * y1_q[WordW-1:HalfW];
  assign p10_d = x1_q[WordW-1:HalfW] * y1_q[HalfW-1:0];
  assign p11_d = x1_q[WordW-1:HalfW] * y1_q[WordW-1:HalfW];

  assign prod_sum = {{WordW{1'b0}}, p00_q}
                  + {{HalfW{1'b0}}, p01_q, {HalfW{1'b0}}}
                  + {{HalfW{1'b0}}, p10_q, {HalfW{1'b0}}}
                  + {p11_q, {WordW{1'b0}}};

  assign sum = acc_q + {{WordW{1'b0}}, prod_q};

  assign push_o.valid = advance && v3_q && last3_q;
  assign push_o.total = sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      acc_q <= '0;
    end else if (advance) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v3_q) begin
        acc_q <= last3_q ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x1_q    <= in_i.x_value;
      y1_q    <= in_i.y_value;
      last1_q <= in_i.last;
      p00_q   <= p00_d;
      p01_q   <= p01_d;
      p10_q   <= p10_d;
      p11_q   <= p11_d;
      last2_q <= last1_q;
      prod_q  <= prod_sum;
      last3_q <= last2_q;
    end
  end

endmodule

/* sv/mdp_queue.sv */
// Short queue of finished totals between the front and the back part.
// Depends on mdp_pkg.
`timescale 1ns / 1ps

module mdp_queue import mdp_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  total_req_t push_i,
  output logic       full_o,
  output total_req_t head_o,
  input  logic       pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  acc_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign do_push = push_i.valid;
  assign do_pop  = pop_i && (count_q != '0);

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.total = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.total;
    end
  end

endmodule

/* sv/mdp_back.sv */
// Back part: reduces one 192-bit total modulo the modulus, one bit per cycle,
// and holds the residue in an output register. Depends on mdp_pkg, mdp_if.
`timescale 1ns / 1ps

module mdp_back import mdp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  total_req_t       head_i,
  output logic             pop_o,
  input  logic [WordW-1:0] modulus_i,
  mdp_out_if.source        out_o
);

  back_state_e        state_q, state_d;
  logic [RedCntW-1:0] cnt_q;
  acc_t               shreg_q;
  logic [WordW-1:0]   rem_q;
  logic [WordW:0]     step_sh, step_rem;
  logic               out_valid_q;
  logic [WordW-1:0]   out_res_q;
  logic               out_load;

  // The remainder stays below the modulus, so twice it plus one bit needs at
  // most one subtraction.
  assign step_sh  = {rem_q, shreg_q[AccW-1]};
  assign step_rem = (step_sh >= {1'b0, modulus_i}) ? step_sh - {1'b0, modulus_i}
                                                   : step_sh;

  assign pop_o    = (state_q == ST_IDLE) && head_i.valid;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign out_o.valid   = out_valid_q;
  assign out_o.residue = out_res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      shreg_q <= head_i.total;
      rem_q   <= '0;
      cnt_q   <= RedCntW'(AccW - 1);
    end else if (state_q == ST_RUN) begin
      shreg_q <= shreg_q << 1;
      rem_q   <= step_rem[WordW-1:0];
      cnt_q   <= cnt_q - 1'b1;
    end
    // A zero modulus gives a residue of zero by definition.
    if (out_load) begin
      out_res_q <= (modulus_i == '0) ? '0 : rem_q;
    end
  end

endmodule
